// ===== rtl/core/flow_mix_pkg.sv =====
package flow_mix_pkg;

  localparam int GRAD_FRAC_DEFAULT = 16;
  localparam int GRAD_FRAC_MIN     = 8;
  localparam int OUT_FRAC          = 16;
  localparam int MAG_W             = 36;
  localparam int MIX_W             = 17;
  localparam int SUM_W             = 68;
  localparam int RAD_W             = 2 * MAG_W;
  localparam int EXT_W             = SUM_W + 2 * OUT_FRAC - 2 * GRAD_FRAC_MIN;
  localparam int REM_W             = MAG_W + 3;
  localparam int DEN_W             = MAG_W + 1;
  localparam int DREM_W            = MAG_W + 2;

  typedef struct packed {
    logic signed [31:0] gxx;
    logic signed [31:0] gxy;
    logic signed [31:0] gxz;
    logic signed [31:0] gyx;
    logic signed [31:0] gyy;
    logic signed [31:0] gyz;
    logic signed [31:0] gzx;
    logic signed [31:0] gzy;
    logic signed [31:0] gzz;
    logic [MAG_W-1:0]   supplied_shear;
    logic               last_particle;
  } in_word_t;

  typedef struct packed {
    logic [MAG_W-1:0] shear_rate;
    logic [MAG_W-1:0] vorticity;
    logic [MIX_W-1:0] mixing_index;
    logic             last_out;
  } out_word_t;

  typedef struct packed {
    logic [REM_W-3:0] rem;
    logic [MAG_W-1:0] root;
  } root_st_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [MIX_W-1:0]  quo;
  } div_st_t;

  function automatic root_st_t root_step(input root_st_t s, input logic [1:0] two);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    root_st_t r;
    t     = {s.rem, two};
    trial = {1'b0, s.root, 2'b01};
    if (t >= trial) begin
      r.rem  = (REM_W-2)'(t - trial);
      r.root = {s.root[MAG_W-2:0], 1'b1};
    end else begin
      r.rem  = (REM_W-2)'(t);
      r.root = {s.root[MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_st_t div_step(input div_st_t s, input logic [DEN_W-1:0] den);
    logic [DREM_W-1:0] d;
    div_st_t r;
    d = {1'b0, den};
    if (s.rem >= d) begin
      r.rem = DREM_W'({s.rem - d, 1'b0});
      r.quo = {s.quo[MIX_W-2:0], 1'b1};
    end else begin
      r.rem = DREM_W'({s.rem, 1'b0});
      r.quo = {s.quo[MIX_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

// ===== rtl/core/flow_type_mixing_index_unit.sv =====
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | in_data (in_word_t)
// out     | output    | out_valid / out_ready | out_data (out_word_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (compute_shear_rate)
// one word per cycle while out is not stalled; 4 front stages (magnitudes, squares, sums,
// scaling), 36 square root stages, a select stage and 17 divider stages, then out
// the whole pipe advances together; a stall on out holds every stage in place
// synchronous reset clears the valid bits and sets compute_shear_rate
module flow_type_mixing_index_unit
  import flow_mix_pkg::*;
#(
  parameter int GRAD_FRAC_BITS = GRAD_FRAC_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int SQ  = MAG_W;
  localparam int DV  = MIX_W;
  localparam int SHL = (GRAD_FRAC_BITS <= OUT_FRAC) ? 2 * OUT_FRAC - 2 * GRAD_FRAC_BITS : 0;
  localparam int SHR = (GRAD_FRAC_BITS > OUT_FRAC) ? 2 * GRAD_FRAC_BITS - 2 * OUT_FRAC : 0;

  logic compute_shear_rate;
  logic en;

  // stage 1: magnitudes
  logic              v1;
  logic [32:0]       m1 [6];
  logic [32:0]       w1 [3];
  logic [MAG_W-1:0]  sup1;
  logic              last1, cmp1;
  // stage 2: squares
  logic              v2;
  logic [65:0]       m2 [6];
  logic [65:0]       w2 [3];
  logic [MAG_W-1:0]  sup2;
  logic              last2, cmp2;
  // stage 3: sums
  logic              v3;
  logic [SUM_W-1:0]  sg3, sw3;
  logic [MAG_W-1:0]  sup3;
  logic              last3, cmp3;
  // root pipe, lane 0 shear, lane 1 vorticity
  logic              sv   [0:SQ];
  logic [RAD_W-1:0]  xs   [0:SQ][2];
  root_st_t          rs   [0:SQ][2];
  logic              sat  [0:SQ][2];
  logic [MAG_W-1:0]  supq [0:SQ];
  logic              lstq [0:SQ];
  logic              cmpq [0:SQ];
  // divider pipe
  logic              dv   [0:DV];
  div_st_t           ds   [0:DV];
  logic [DEN_W-1:0]  den  [0:DV];
  logic [MAG_W-1:0]  gam  [0:DV];
  logic [MAG_W-1:0]  omg  [0:DV];
  logic              lstd [0:DV];

  logic [EXT_W-1:0]  eg, ew;
  logic [MAG_W-1:0]  gsel, osel;

  assign en        = !dv[DV] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compute_shear_rate <= 1'b1;
    end else if (cfg_valid) begin
      compute_shear_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i <= SQ; i++) sv[i] <= 1'b0;
      for (int i = 0; i <= DV; i++) dv[i] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      sv[0] <= v3;
      for (int i = 0; i < SQ; i++) sv[i+1] <= sv[i];
      dv[0] <= sv[SQ];
      for (int i = 0; i < DV; i++) dv[i+1] <= dv[i];
    end
  end

  always_comb begin
    eg = (EXT_W'(sg3) << SHL) >> SHR;
    ew = (EXT_W'(sw3) << SHL) >> SHR;
  end

  always_comb begin
    gsel = cmpq[SQ] ? (sat[SQ][0] ? '1 : rs[SQ][0].root) : supq[SQ];
    osel = sat[SQ][1] ? '1 : rs[SQ][1].root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1[0] <= mag33(33'(in_data.gxx));
      m1[1] <= mag33(33'(in_data.gyy));
      m1[2] <= mag33(33'(in_data.gzz));
      m1[3] <= mag33(33'(in_data.gyx) + 33'(in_data.gxy));
      m1[4] <= mag33(33'(in_data.gzx) + 33'(in_data.gxz));
      m1[5] <= mag33(33'(in_data.gzy) + 33'(in_data.gyz));
      w1[0] <= mag33(33'(in_data.gyx) - 33'(in_data.gxy));
      w1[1] <= mag33(33'(in_data.gzx) - 33'(in_data.gxz));
      w1[2] <= mag33(33'(in_data.gzy) - 33'(in_data.gyz));
      sup1  <= in_data.supplied_shear;
      last1 <= in_data.last_particle;
      cmp1  <= compute_shear_rate;

      for (int i = 0; i < 6; i++) m2[i] <= 66'(m1[i]) * 66'(m1[i]);
      for (int i = 0; i < 3; i++) w2[i] <= 66'(w1[i]) * 66'(w1[i]);
      sup2  <= sup1;
      last2 <= last1;
      cmp2  <= cmp1;

      sg3   <= ((SUM_W'(m2[0]) + SUM_W'(m2[1]) + SUM_W'(m2[2])) << 1)
               + SUM_W'(m2[3]) + SUM_W'(m2[4]) + SUM_W'(m2[5]);
      sw3   <= SUM_W'(w2[0]) + SUM_W'(w2[1]) + SUM_W'(w2[2]);
      sup3  <= sup2;
      last3 <= last2;
      cmp3  <= cmp2;

      xs[0][0]  <= eg[RAD_W-1:0];
      xs[0][1]  <= ew[RAD_W-1:0];
      sat[0][0] <= |eg[EXT_W-1:RAD_W];
      sat[0][1] <= |ew[EXT_W-1:RAD_W];
      rs[0][0]  <= '0;
      rs[0][1]  <= '0;
      supq[0]   <= sup3;
      lstq[0]   <= last3;
      cmpq[0]   <= cmp3;
      for (int i = 0; i < SQ; i++) begin
        for (int l = 0; l < 2; l++) begin
          rs[i+1][l]  <= root_step(rs[i][l], xs[i][l][RAD_W-1:RAD_W-2]);
          xs[i+1][l]  <= xs[i][l] << 2;
          sat[i+1][l] <= sat[i][l];
        end
        supq[i+1] <= supq[i];
        lstq[i+1] <= lstq[i];
        cmpq[i+1] <= cmpq[i];
      end

      ds[0].rem <= DREM_W'(gsel);
      ds[0].quo <= '0;
      den[0]    <= DEN_W'(gsel) + DEN_W'(osel);
      gam[0]    <= gsel;
      omg[0]    <= osel;
      lstd[0]   <= lstq[SQ];
      for (int i = 0; i < DV; i++) begin
        ds[i+1]   <= div_step(ds[i], den[i]);
        den[i+1]  <= den[i];
        gam[i+1]  <= gam[i];
        omg[i+1]  <= omg[i];
        lstd[i+1] <= lstd[i];
      end
    end
  end

  // zero denominator gives a zero index
  assign out_valid              = dv[DV];
  assign out_data.shear_rate    = gam[DV];
  assign out_data.vorticity     = omg[DV];
  assign out_data.mixing_index  = (den[DV] == '0) ? '0 : ds[DV].quo;
  assign out_data.last_out      = lstd[DV];

endmodule
